>>> rtl/core/srcs_pkg.sv
// Shared constants and codes for the segment/rectangle clip splitter.
// No dependencies; all other files but srcs_if import this package.
package srcs_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;
    localparam int LANES          = 4;

    typedef enum logic [1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_HALF_WIDTH  = 2'd2,
        REG_HALF_HEIGHT = 2'd3
    } reg_idx_t;

endpackage

>>> rtl/core/srcs_if.sv
// Valid/ready channel interfaces for segments in and pieces out.
// Standalone; widths follow COORD_BITS.
interface srcs_seg_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface srcs_piece_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] piece_start_x;
    logic signed [COORD_BITS-1:0] piece_start_y;
    logic signed [COORD_BITS-1:0] piece_end_x;
    logic signed [COORD_BITS-1:0] piece_end_y;
    logic                         is_inside;
    logic                         last_piece;

    modport source (output valid, piece_start_x, piece_start_y, piece_end_x, piece_end_y,
                    is_inside, last_piece, input ready);
    modport sink   (input valid, piece_start_x, piece_start_y, piece_end_x, piece_end_y,
                    is_inside, last_piece, output ready);
endinterface

>>> rtl/core/segment_rect_clip_splitter_top.sv
// Top level of the segment/rectangle clip splitter.
// Depends on srcs_pkg, srcs_if, srcs_regs, srcs_front, srcs_div, srcs_split.
//
//   channel | direction | handshake            | moves per transfer
//   --------+-----------+----------------------+---------------------------------
//   seg     | in        | valid/ready          | one segment (start, end)
//   piece   | out       | valid/ready          | one piece, is_inside, last_piece
//   apb     | in        | psel/penable/pready  | one register write or read
//
// A segment can be taken every cycle while the piece list is free. It gives
// one to three pieces, one per cycle while piece is ready, and the list frees
// when the last of them moves to the output register. A segment passes five
// front stages, COORD_BITS + 1 divider stages, the piece list and the output
// register. Reset clears all valid bits and the registers. A stall on piece
// holds front and divider once a segment waits; nothing is lost or repeated.
module segment_rect_clip_splitter_top
    import srcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    srcs_seg_if.sink              seg,
    srcs_piece_if.source          piece
);

    localparam int CW = COORD_BITS;
    localparam int SW = 4 * CW + 3;

    logic signed [CW-1:0] x_min, x_max, y_min, y_max;
    logic                 advance, take;
    logic                 front_valid, div_valid;
    logic [2*CW+1:0]      front_num [LANES];
    logic [CW:0]          front_den [LANES];
    logic [SW-1:0]        front_side, div_side;
    logic [CW:0]          div_quot [LANES];

    assign advance   = !div_valid || take;
    assign seg.ready = advance;

    srcs_regs #(.COORD_BITS(CW)) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .x_min   (x_min),
        .x_max   (x_max),
        .y_min   (y_min),
        .y_max   (y_max)
    );

    srcs_front #(.COORD_BITS(CW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (seg.valid),
        .x0        (seg.start_x),
        .y0        (seg.start_y),
        .x1        (seg.end_x),
        .y1        (seg.end_y),
        .x_min     (x_min),
        .x_max     (x_max),
        .y_min     (y_min),
        .y_max     (y_max),
        .out_valid (front_valid),
        .num       (front_num),
        .den       (front_den),
        .side      (front_side)
    );

    srcs_div #(.COORD_BITS(CW), .SIDE_W(SW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (front_valid),
        .num       (front_num),
        .den       (front_den),
        .side_in   (front_side),
        .out_valid (div_valid),
        .quot      (div_quot),
        .side_out  (div_side)
    );

    srcs_split #(.COORD_BITS(CW), .SIDE_W(SW)) u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .quot     (div_quot),
        .side     (div_side),
        .take     (take),
        .piece    (piece)
    );

endmodule

>>> rtl/core/srcs_regs.sv
// APB register file for the clip rectangle and the saturated bounds.
// Depends on srcs_pkg.
module srcs_regs
    import srcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    output logic signed [COORD_BITS-1:0] x_min,
    output logic signed [COORD_BITS-1:0] x_max,
    output logic signed [COORD_BITS-1:0] y_min,
    output logic signed [COORD_BITS-1:0] y_max
);

    localparam int CW = COORD_BITS;

    logic [CW-1:0] center_x_reg;
    logic [CW-1:0] center_y_reg;
    logic [CW-2:0] half_w_reg;
    logic [CW-2:0] half_h_reg;
    reg_idx_t      idx;
    logic          wr;

    function automatic logic [CW-1:0] sat_bound(input logic [CW-1:0] c,
                                                input logic [CW-2:0] h,
                                                input logic sub);
        logic [CW:0] ce;
        logic [CW:0] he;
        logic [CW:0] s;
        logic [CW-1:0] r;
        ce = {c[CW-1], c};
        he = {2'b00, h};
        s  = sub ? ce - he : ce + he;
        if (s[CW] != s[CW-1])
            r = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        else
            r = s[CW-1:0];
        return r;
    endfunction

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            half_w_reg   <= '0;
            half_h_reg   <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_CENTER_X:    center_x_reg <= pwdata[CW-1:0];
                REG_CENTER_Y:    center_y_reg <= pwdata[CW-1:0];
                REG_HALF_WIDTH:  half_w_reg   <= pwdata[CW-2:0];
                REG_HALF_HEIGHT: half_h_reg   <= pwdata[CW-2:0];
            endcase
        end
    end

    assign x_min = $signed(sat_bound(center_x_reg, half_w_reg, 1'b1));
    assign x_max = $signed(sat_bound(center_x_reg, half_w_reg, 1'b0));
    assign y_min = $signed(sat_bound(center_y_reg, half_h_reg, 1'b1));
    assign y_max = $signed(sat_bound(center_y_reg, half_h_reg, 1'b0));

    always_comb
    begin
        unique case (idx)
            REG_CENTER_X:    prdata = APB_DATA_W'(center_x_reg);
            REG_CENTER_Y:    prdata = APB_DATA_W'(center_y_reg);
            REG_HALF_WIDTH:  prdata = APB_DATA_W'(half_w_reg);
            REG_HALF_HEIGHT: prdata = APB_DATA_W'(half_h_reg);
        endcase
    end

endmodule

>>> rtl/core/srcs_front.sv
// Front pipeline: edge offsets, per-axis crossings, entry/exit selection,
// along-segment products. Five register stages. Depends on srcs_pkg.
module srcs_front
    import srcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               in_valid,
    input  logic signed [COORD_BITS-1:0]       x0,
    input  logic signed [COORD_BITS-1:0]       y0,
    input  logic signed [COORD_BITS-1:0]       x1,
    input  logic signed [COORD_BITS-1:0]       y1,
    input  logic signed [COORD_BITS-1:0]       x_min,
    input  logic signed [COORD_BITS-1:0]       x_max,
    input  logic signed [COORD_BITS-1:0]       y_min,
    input  logic signed [COORD_BITS-1:0]       y_max,
    output logic                               out_valid,
    output logic [2*COORD_BITS+1:0]            num [LANES],
    output logic [COORD_BITS:0]                den [LANES],
    output logic [4*COORD_BITS+2:0]            side
);

    localparam int CW = COORD_BITS;
    localparam int FW = CW + 1;
    localparam int NW = 2 * FW;

    typedef struct packed {
        logic          ok;
        logic [CW:0]   en;
        logic [CW:0]   ed;
        logic [CW:0]   ln;
        logic [CW:0]   ld;
    } axis_t;

    function automatic axis_t axis_clip(input logic signed [CW:0] d,
                                        input logic signed [CW:0] ql,
                                        input logic signed [CW:0] qh);
        axis_t       r;
        logic [CW:0] mag;
        logic [CW:0] nql;
        logic [CW:0] nqh;
        r.ok = 1'b1;
        r.en = FW'(0);
        r.ed = FW'(1);
        r.ln = FW'(1);
        r.ld = FW'(1);
        mag  = d[CW] ? FW'(-d) : FW'(d);
        nql  = FW'(-ql);
        nqh  = FW'(-qh);
        if (d == '0)
            r.ok = !ql[CW] && !qh[CW];
        else if (!d[CW])
        begin
            if (ql[CW])
            begin
                if (nql > mag)
                    r.ok = 1'b0;
                else
                begin
                    r.en = nql;
                    r.ed = mag;
                end
            end
            if (qh[CW])
                r.ok = 1'b0;
            else if (FW'(qh) < mag)
            begin
                r.ln = FW'(qh);
                r.ld = mag;
            end
        end
        else
        begin
            if (ql[CW])
                r.ok = 1'b0;
            else if (FW'(ql) < mag)
            begin
                r.ln = FW'(ql);
                r.ld = mag;
            end
            if (qh[CW])
            begin
                if (nqh > mag)
                    r.ok = 1'b0;
                else
                begin
                    r.en = nqh;
                    r.ed = mag;
                end
            end
        end
        return r;
    endfunction

    // stage 1
    logic                 s1_valid_reg;
    logic [CW-1:0]        s1_x0_reg, s1_y0_reg, s1_x1_reg, s1_y1_reg;
    logic signed [CW:0]   s1_dx_reg, s1_dy_reg;
    logic signed [CW:0]   s1_qxl_reg, s1_qxh_reg, s1_qyl_reg, s1_qyh_reg;
    // stage 2
    logic                 s2_valid_reg;
    logic [CW-1:0]        s2_x0_reg, s2_y0_reg, s2_x1_reg, s2_y1_reg;
    axis_t                s2_ax_reg, s2_ay_reg;
    logic [CW:0]          s2_mx_reg, s2_my_reg;
    logic                 s2_sx_reg, s2_sy_reg;
    // stage 3
    logic                 s3_valid_reg;
    logic [CW-1:0]        s3_x0_reg, s3_y0_reg, s3_x1_reg, s3_y1_reg;
    axis_t                s3_ax_reg, s3_ay_reg;
    logic [CW:0]          s3_mx_reg, s3_my_reg;
    logic                 s3_sx_reg, s3_sy_reg, s3_ok_reg;
    logic [NW-1:0]        s3_pe1_reg, s3_pe2_reg, s3_pl1_reg, s3_pl2_reg;
    // stage 4
    logic                 s4_valid_reg;
    logic [CW-1:0]        s4_x0_reg, s4_y0_reg, s4_x1_reg, s4_y1_reg;
    logic [CW:0]          s4_en_reg, s4_ed_reg, s4_ln_reg, s4_ld_reg;
    logic [CW:0]          s4_mx_reg, s4_my_reg;
    logic                 s4_sx_reg, s4_sy_reg, s4_ok_reg;
    // stage 5
    logic                 s5_valid_reg;
    logic [CW-1:0]        s5_x0_reg, s5_y0_reg, s5_x1_reg, s5_y1_reg;
    logic [CW:0]          s5_ed_reg, s5_ld_reg;
    logic                 s5_sx_reg, s5_sy_reg, s5_ok_reg;
    logic [NW-1:0]        s5_c1_reg, s5_c2_reg;
    logic [NW-1:0]        s5_ma_reg, s5_mb_reg, s5_mc_reg, s5_md_reg;

    axis_t                ax_next, ay_next;
    logic                 hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_comb
    begin
        ax_next = axis_clip(s1_dx_reg, s1_qxl_reg, s1_qxh_reg);
        ay_next = axis_clip(s1_dy_reg, s1_qyl_reg, s1_qyh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x0_reg  <= x0;
            s1_y0_reg  <= y0;
            s1_x1_reg  <= x1;
            s1_y1_reg  <= y1;
            s1_dx_reg  <= FW'(x1) - FW'(x0);
            s1_dy_reg  <= FW'(y1) - FW'(y0);
            s1_qxl_reg <= FW'(x0) - FW'(x_min);
            s1_qxh_reg <= FW'(x_max) - FW'(x0);
            s1_qyl_reg <= FW'(y0) - FW'(y_min);
            s1_qyh_reg <= FW'(y_max) - FW'(y0);

            s2_x0_reg <= s1_x0_reg;
            s2_y0_reg <= s1_y0_reg;
            s2_x1_reg <= s1_x1_reg;
            s2_y1_reg <= s1_y1_reg;
            s2_ax_reg <= ax_next;
            s2_ay_reg <= ay_next;
            s2_mx_reg <= s1_dx_reg[CW] ? FW'(-s1_dx_reg) : FW'(s1_dx_reg);
            s2_my_reg <= s1_dy_reg[CW] ? FW'(-s1_dy_reg) : FW'(s1_dy_reg);
            s2_sx_reg <= s1_dx_reg[CW];
            s2_sy_reg <= s1_dy_reg[CW];

            s3_x0_reg  <= s2_x0_reg;
            s3_y0_reg  <= s2_y0_reg;
            s3_x1_reg  <= s2_x1_reg;
            s3_y1_reg  <= s2_y1_reg;
            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;
            s3_mx_reg  <= s2_mx_reg;
            s3_my_reg  <= s2_my_reg;
            s3_sx_reg  <= s2_sx_reg;
            s3_sy_reg  <= s2_sy_reg;
            s3_ok_reg  <= s2_ax_reg.ok && s2_ay_reg.ok;
            s3_pe1_reg <= NW'(s2_ax_reg.en) * NW'(s2_ay_reg.ed);
            s3_pe2_reg <= NW'(s2_ay_reg.en) * NW'(s2_ax_reg.ed);
            s3_pl1_reg <= NW'(s2_ax_reg.ln) * NW'(s2_ay_reg.ld);
            s3_pl2_reg <= NW'(s2_ay_reg.ln) * NW'(s2_ax_reg.ld);

            s4_x0_reg <= s3_x0_reg;
            s4_y0_reg <= s3_y0_reg;
            s4_x1_reg <= s3_x1_reg;
            s4_y1_reg <= s3_y1_reg;
            s4_mx_reg <= s3_mx_reg;
            s4_my_reg <= s3_my_reg;
            s4_sx_reg <= s3_sx_reg;
            s4_sy_reg <= s3_sy_reg;
            s4_ok_reg <= s3_ok_reg;
            if (s3_pe1_reg < s3_pe2_reg)
            begin
                s4_en_reg <= s3_ay_reg.en;
                s4_ed_reg <= s3_ay_reg.ed;
            end
            else
            begin
                s4_en_reg <= s3_ax_reg.en;
                s4_ed_reg <= s3_ax_reg.ed;
            end
            if (s3_pl2_reg < s3_pl1_reg)
            begin
                s4_ln_reg <= s3_ay_reg.ln;
                s4_ld_reg <= s3_ay_reg.ld;
            end
            else
            begin
                s4_ln_reg <= s3_ax_reg.ln;
                s4_ld_reg <= s3_ax_reg.ld;
            end

            s5_x0_reg <= s4_x0_reg;
            s5_y0_reg <= s4_y0_reg;
            s5_x1_reg <= s4_x1_reg;
            s5_y1_reg <= s4_y1_reg;
            s5_ed_reg <= s4_ed_reg;
            s5_ld_reg <= s4_ld_reg;
            s5_sx_reg <= s4_sx_reg;
            s5_sy_reg <= s4_sy_reg;
            s5_ok_reg <= s4_ok_reg;
            s5_c1_reg <= NW'(s4_ln_reg) * NW'(s4_ed_reg);
            s5_c2_reg <= NW'(s4_en_reg) * NW'(s4_ld_reg);
            s5_ma_reg <= NW'(s4_mx_reg) * NW'(s4_en_reg);
            s5_mb_reg <= NW'(s4_my_reg) * NW'(s4_en_reg);
            s5_mc_reg <= NW'(s4_mx_reg) * NW'(s4_ln_reg);
            s5_md_reg <= NW'(s4_my_reg) * NW'(s4_ln_reg);
        end
    end

    assign hit       = s5_ok_reg && !(s5_c1_reg < s5_c2_reg);
    assign out_valid = s5_valid_reg;
    assign num[0]    = s5_ma_reg;
    assign num[1]    = s5_mb_reg;
    assign num[2]    = s5_mc_reg;
    assign num[3]    = s5_md_reg;
    assign den[0]    = s5_ed_reg;
    assign den[1]    = s5_ed_reg;
    assign den[2]    = s5_ld_reg;
    assign den[3]    = s5_ld_reg;
    assign side      = {hit, s5_sx_reg, s5_sy_reg, s5_x0_reg, s5_y0_reg, s5_x1_reg, s5_y1_reg};

endmodule

>>> rtl/core/srcs_div.sv
// Pipelined restoring divider, four lanes, one quotient bit per stage,
// with a side word carried alongside. Depends on srcs_pkg.
module srcs_div
    import srcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SIDE_W     = 4 * COORD_BITS_DEF + 3
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  logic [2*COORD_BITS+1:0]    num [LANES],
    input  logic [COORD_BITS:0]        den [LANES],
    input  logic [SIDE_W-1:0]          side_in,
    output logic                       out_valid,
    output logic [COORD_BITS:0]        quot [LANES],
    output logic [SIDE_W-1:0]          side_out
);

    localparam int FW = COORD_BITS + 1;
    localparam int NW = 2 * FW;
    localparam int QB = FW;

    logic [NW-1:0]     rem_reg  [QB][LANES];
    logic [FW-1:0]     den_reg  [QB][LANES];
    logic [FW-1:0]     quo_reg  [QB][LANES];
    logic              valid_reg[QB];
    logic [SIDE_W-1:0] side_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        localparam int B = QB - 1 - k;

        logic [NW-1:0]     rem_in  [LANES];
        logic [FW-1:0]     den_in  [LANES];
        logic [FW-1:0]     quo_in  [LANES];
        logic              v_in;
        logic [SIDE_W-1:0] s_in;
        logic [NW-1:0]     shifted [LANES];
        logic [NW-1:0]     rem_next[LANES];
        logic [FW-1:0]     quo_next[LANES];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = num[l];
                    den_in[l] = den[l];
                    quo_in[l] = '0;
                end
                v_in = in_valid;
                s_in = side_in;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = rem_reg[k-1][l];
                    den_in[l] = den_reg[k-1][l];
                    quo_in[l] = quo_reg[k-1][l];
                end
                v_in = valid_reg[k-1];
                s_in = side_reg[k-1];
            end
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                shifted[l] = NW'(den_in[l]) << B;
                if (rem_in[l] >= shifted[l])
                begin
                    rem_next[l] = rem_in[l] - shifted[l];
                    quo_next[l] = quo_in[l] | (FW'(1) << B);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (advance)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[l];
                    den_reg[k][l] <= den_in[l];
                    quo_reg[k][l] <= quo_next[l];
                end
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign side_out  = side_reg[QB-1];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quot[l] = quo_reg[QB-1][l];
    end

endmodule

>>> rtl/core/srcs_split.sv
// Crossing points, piece list, and the output register that sends one piece
// per transfer. Depends on srcs_pkg and srcs_piece_if.
module srcs_split
    import srcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SIDE_W     = 4 * COORD_BITS_DEF + 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [COORD_BITS:0]   quot [LANES],
    input  logic [SIDE_W-1:0]     side,
    output logic                  take,
    srcs_piece_if.source          piece
);

    localparam int CW = COORD_BITS;

    function automatic logic [CW-1:0] along(input logic [CW-1:0] base,
                                            input logic neg,
                                            input logic [CW:0] off);
        logic [CW+1:0] b;
        logic [CW+1:0] o;
        logic [CW+1:0] s;
        b = {{2{base[CW-1]}}, base};
        o = {1'b0, off};
        s = neg ? b - o : b + o;
        return s[CW-1:0];
    endfunction

    logic [CW-1:0] sx0, sy0, sx1, sy1, ax, ay, bx, by;
    logic          hit, negx, negy;

    logic [CW-1:0] n_ax [3];
    logic [CW-1:0] n_ay [3];
    logic [CW-1:0] n_bx [3];
    logic [CW-1:0] n_by [3];
    logic [2:0]    n_ins;
    logic [2:0]    n_keep;

    logic [CW-1:0] p_ax_reg [3];
    logic [CW-1:0] p_ay_reg [3];
    logic [CW-1:0] p_bx_reg [3];
    logic [CW-1:0] p_by_reg [3];
    logic [2:0]    ins_reg;
    logic [2:0]    keep_reg;

    logic          out_valid_reg;
    logic [CW-1:0] o_ax_reg, o_ay_reg, o_bx_reg, o_by_reg;
    logic          o_ins_reg, o_last_reg;

    logic [1:0]    sel;
    logic [2:0]    keep_after;
    logic          load_out;

    assign sy1  = side[CW-1:0];
    assign sx1  = side[2*CW-1:CW];
    assign sy0  = side[3*CW-1:2*CW];
    assign sx0  = side[4*CW-1:3*CW];
    assign negy = side[4*CW];
    assign negx = side[4*CW+1];
    assign hit  = side[4*CW+2];

    always_comb
    begin
        ax = along(sx0, negx, quot[0]);
        ay = along(sy0, negy, quot[1]);
        bx = along(sx0, negx, quot[2]);
        by = along(sy0, negy, quot[3]);

        n_ax[0] = sx0; n_ay[0] = sy0; n_bx[0] = ax;  n_by[0] = ay;
        n_ax[1] = ax;  n_ay[1] = ay;  n_bx[1] = bx;  n_by[1] = by;
        n_ax[2] = bx;  n_ay[2] = by;  n_bx[2] = sx1; n_by[2] = sy1;
        n_ins   = 3'b010;
        n_keep  = {(bx != sx1) || (by != sy1),
                   (ax != bx) || (ay != by),
                   (sx0 != ax) || (sy0 != ay)};
        if (!hit || n_keep == 3'b000)
        begin
            n_bx[0] = sx1;
            n_by[0] = sy1;
            n_ins   = {2'b00, hit};
            n_keep  = 3'b001;
        end
    end

    always_comb
    begin
        if (keep_reg[0])
            sel = 2'd0;
        else if (keep_reg[1])
            sel = 2'd1;
        else
            sel = 2'd2;
        keep_after      = keep_reg;
        keep_after[sel] = 1'b0;
    end

    assign load_out = (keep_reg != 3'b000) && (!out_valid_reg || piece.ready);
    assign take     = (keep_reg == 3'b000) || (load_out && keep_after == 3'b000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                keep_reg <= in_valid ? n_keep : 3'b000;
            else if (load_out)
                keep_reg <= keep_after;
            if (!out_valid_reg || piece.ready)
                out_valid_reg <= load_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            p_ax_reg <= n_ax;
            p_ay_reg <= n_ay;
            p_bx_reg <= n_bx;
            p_by_reg <= n_by;
            ins_reg  <= n_ins;
        end
        if (load_out)
        begin
            o_ax_reg   <= p_ax_reg[sel];
            o_ay_reg   <= p_ay_reg[sel];
            o_bx_reg   <= p_bx_reg[sel];
            o_by_reg   <= p_by_reg[sel];
            o_ins_reg  <= ins_reg[sel];
            o_last_reg <= (keep_after == 3'b000);
        end
    end

    assign piece.valid         = out_valid_reg;
    assign piece.piece_start_x = $signed(o_ax_reg);
    assign piece.piece_start_y = $signed(o_ay_reg);
    assign piece.piece_end_x   = $signed(o_bx_reg);
    assign piece.piece_end_y   = $signed(o_by_reg);
    assign piece.is_inside     = o_ins_reg;
    assign piece.last_piece    = o_last_reg;

endmodule

>>> rtl/core/srcs_checker.sv
// Port-level checker for the clip splitter, bound to the top level.
// Depends on srcs_pkg and segment_rect_clip_splitter_top.
module srcs_checker
    import srcs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  seg_valid,
    input logic                  seg_ready,
    input logic                  piece_valid,
    input logic                  piece_ready,
    input logic [COORD_BITS-1:0] piece_start_x,
    input logic [COORD_BITS-1:0] piece_start_y,
    input logic [COORD_BITS-1:0] piece_end_x,
    input logic [COORD_BITS-1:0] piece_end_y,
    input logic                  is_inside,
    input logic                  last_piece
);

    logic                  seg_xfer, piece_xfer;
    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                  open_reg;
    logic [1:0]            cnt_reg;
    logic [7:0]            pend_reg;

    assign seg_xfer   = seg_valid && seg_ready;
    assign piece_xfer = piece_valid && piece_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            pend_reg <= 8'd0;
        end
        else
        begin
            if (piece_xfer)
            begin
                open_reg <= !last_piece;
                cnt_reg  <= last_piece ? 2'd0 : cnt_reg + 2'd1;
            end
            pend_reg <= pend_reg + 8'(seg_xfer) - 8'(piece_xfer && last_piece);
        end
    end

    always_ff @(posedge clk)
    begin
        if (piece_xfer)
        begin
            prev_x_reg <= piece_end_x;
            prev_y_reg <= piece_end_y;
        end
    end

    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        piece_xfer && open_reg |-> piece_start_x == prev_x_reg && piece_start_y == prev_y_reg)
        else $error("piece does not start where the previous one ended");

    a_three: assert property (@(posedge clk) disable iff (!rst_n)
        piece_xfer && cnt_reg == 2'd2 |-> last_piece)
        else $error("more than three pieces for one segment");

    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        piece_xfer && last_piece |-> pend_reg != 8'd0)
        else $error("last piece without an outstanding segment");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && !piece_ready |=> piece_valid
            && $stable({piece_start_x, piece_start_y, piece_end_x, piece_end_y,
                        is_inside, last_piece}))
        else $error("stalled piece changed");

endmodule

bind segment_rect_clip_splitter_top srcs_checker #(.COORD_BITS(COORD_BITS)) u_srcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .seg_valid     (seg.valid),
    .seg_ready     (seg.ready),
    .piece_valid   (piece.valid),
    .piece_ready   (piece.ready),
    .piece_start_x (piece.piece_start_x),
    .piece_start_y (piece.piece_start_y),
    .piece_end_x   (piece.piece_end_x),
    .piece_end_y   (piece.piece_end_y),
    .is_inside     (piece.is_inside),
    .last_piece    (piece.last_piece)
);
